// File: rtl/core/scl_pkg.sv
// shared types, character constants and helper functions for the serial command line parser
// no dependencies; imported by scl_line_state and serial_command_line_parser
`default_nettype none

package scl_pkg;

  // default parameter values
  localparam int unsigned MaxLineDef = 2047;
  localparam int unsigned MaxArgsDef = 11;

  // line format constants
  localparam int unsigned MinLine     = 7;
  localparam logic [7:0]  CharLt      = 8'h3C;  // '<'
  localparam logic [7:0]  CharZero    = 8'h30;  // '0'
  localparam logic [7:0]  CharNine    = 8'h39;  // '9'
  localparam logic [7:0]  CharSemi    = 8'h3B;  // ';'
  localparam logic [7:0]  CharComma   = 8'h2C;  // ','
  localparam logic [7:0]  CharCr      = 8'h0D;
  localparam logic [7:0]  CharLf      = 8'h0A;
  localparam logic [7:0]  CharPlus    = 8'h2B;
  localparam logic [7:0]  CharMinus   = 8'h2D;
  localparam logic [7:0]  CharSpace   = 8'h20;
  localparam logic [7:0]  CharTab     = 8'h09;
  localparam logic [23:0] CmdTextSts  = 24'h535453;
  localparam logic [23:0] CmdTextIdd  = 24'h494444;
  localparam logic [23:0] CmdTextGga  = 24'h474741;
  localparam logic [7:0]  PermitValue = 8'd100;
  localparam logic [3:0]  PermitArg   = 4'd2;   // field that carries the permission value
  localparam logic [7:0]  ArgSat      = 8'd255;

  typedef enum logic [1:0] {
    CMD_UNKNOWN = 2'd0,
    CMD_STS     = 2'd1,
    CMD_IDD     = 2'd2,
    CMD_GGA     = 2'd3
  } cmd_code_e;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } arg_phase_e;

  // interpretation state of the line body
  typedef struct packed {
    logic [23:0] cmd_chars;
    logic [1:0]  cmd_len;
    logic [3:0]  field_num;
    logic [7:0]  arg_val;
    arg_phase_e  arg_phase;
    logic        arg_neg;
  } body_t;

  // view of the current line handed to the report logic
  typedef struct packed {
    logic        len_zero;
    logic        len_over;
    logic        len_ge_min;
    logic        prefix_ok;
    logic [7:0]  run_xor;
    logic [23:0] tail;
    body_t       body;
  } line_view_t;

  function automatic logic is_blank(logic [7:0] c);
    is_blank = (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    is_digit = (c >= CharZero) && (c <= CharNine);
  endfunction

  // 16 marks a non-hex character
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      v = {1'b0, c[3:0] + 4'd9};
    return v;
  endfunction

  // strtoul-style read of the two checksum characters, modulo 256
  function automatic logic [7:0] read_checksum(logic [7:0] hi, logic [7:0] lo);
    logic [1:0][7:0] ch;
    logic [1:0]      start;
    logic            neg;
    logic            stop;
    logic [4:0]      hv;
    logic [7:0]      v;
    ch[0] = hi;
    ch[1] = lo;
    start = is_blank(hi) ? 2'd1 : 2'd0;
    neg = 1'b0;
    stop = 1'b0;
    v = 8'd0;
    if (ch[start[0]] == CharPlus || ch[start[0]] == CharMinus) begin
      if (start != 2'd2) begin
        neg = (ch[start[0]] == CharMinus);
        start = start + 2'd1;
      end
    end
    for (int k = 0; k < 2; k++) begin
      hv = hex_value(ch[k]);
      if (2'(k) >= start) begin
        if (!stop && !hv[4]) v = {v[3:0], hv[3:0]};
        else stop = 1'b1;
      end
    end
    if (neg) v = 8'd0 - v;
    return v;
  endfunction

  // one body byte through the command, comma and argument readers
  function automatic body_t body_step(body_t s, logic [7:0] c, logic [3:0] max_args);
    body_t       r;
    logic [11:0] acc;
    r = s;
    acc = 12'({4'd0, s.arg_val}) * 12'd10 + {8'd0, c[3:0]};
    if (c == CharComma) begin
      if (s.field_num == PermitArg) r.arg_phase = PH_DONE;
      if (s.field_num < max_args) r.field_num = s.field_num + 4'd1;
    end else if (s.field_num == 4'd0) begin
      if (s.cmd_len != 2'd3) begin
        r.cmd_chars = {s.cmd_chars[15:0], c};
        r.cmd_len = s.cmd_len + 2'd1;
      end
    end else if (s.field_num == PermitArg && s.arg_phase != PH_DONE) begin
      if (s.arg_phase == PH_SKIP) begin
        if (is_blank(c)) begin
          r.arg_phase = PH_SKIP;
        end else if (c == CharPlus) begin
          r.arg_phase = PH_DIGITS;
        end else if (c == CharMinus) begin
          r.arg_phase = PH_DIGITS;
          r.arg_neg = 1'b1;
        end else if (is_digit(c)) begin
          r.arg_val = {4'd0, c[3:0]};
          r.arg_phase = PH_DIGITS;
        end else begin
          r.arg_phase = PH_DONE;
        end
      end else if (is_digit(c)) begin
        r.arg_val = (acc > 12'(ArgSat)) ? ArgSat : acc[7:0];
      end else begin
        r.arg_phase = PH_DONE;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/scl_line_state.sv
// per-line state: length, prefix check, running xor, three-byte tail and body readers
// depends on scl_pkg
`default_nettype none

module scl_line_state import scl_pkg::*; #(
  parameter int unsigned MAX_LINE = MaxLineDef,
  parameter int unsigned MAX_ARGS = MaxArgsDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       data_en_i,   // non-terminator byte
  input  wire logic       clear_i,     // terminator byte
  input  wire logic [7:0] byte_i,
  output line_view_t      view_o
);

  localparam int unsigned LenW = $clog2(MAX_LINE + 2);

  logic [LenW-1:0] len_q, len_d;
  logic            prefix_q, prefix_d;
  logic [7:0]      xor_q, xor_d;
  logic [23:0]     tail_q, tail_d;
  body_t           body_q, body_d;
  logic            take;

  assign take = data_en_i && (len_q <= LenW'(MAX_LINE));

  always_comb begin
    len_d = len_q;
    prefix_d = prefix_q;
    xor_d = xor_q;
    tail_d = tail_q;
    body_d = body_q;
    if (clear_i) begin
      len_d = '0;
      prefix_d = 1'b1;
      xor_d = '0;
      tail_d = '0;
      body_d = '0;
    end else if (take) begin
      if (len_q == LenW'(0)) begin
        if (byte_i != CharLt) prefix_d = 1'b0;
      end else if (len_q < LenW'(3)) begin
        if (byte_i != CharZero) prefix_d = 1'b0;
      end
      // body bytes are read three bytes late
      if (len_q >= LenW'(6)) body_d = body_step(body_q, tail_q[23:16], 4'(MAX_ARGS));
      tail_d = {tail_q[15:0], byte_i};
      xor_d = xor_q ^ byte_i;
      len_d = len_q + LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      prefix_q <= 1'b1;
      xor_q <= '0;
      tail_q <= '0;
      body_q <= '0;
    end else begin
      len_q <= len_d;
      prefix_q <= prefix_d;
      xor_q <= xor_d;
      tail_q <= tail_d;
      body_q <= body_d;
    end
  end

  assign view_o.len_zero = (len_q == '0);
  assign view_o.len_over = (len_q > LenW'(MAX_LINE));
  assign view_o.len_ge_min = (len_q >= LenW'(MinLine));
  assign view_o.prefix_ok = prefix_q;
  assign view_o.run_xor = xor_q;
  assign view_o.tail = tail_q;
  assign view_o.body = body_q;

endmodule

`default_nettype wire

// File: rtl/core/serial_command_line_parser.sv
// serial command line parser: a line end passes through the input register and then the
// result register before its report is valid; throughput one byte per cycle; a byte waits
// in the input register only when it ends a non-empty line while the result register is full and stalled
// reset clears the sticky flags and the line state; results appear only for non-empty lines
// depends on scl_pkg and scl_line_state
`default_nettype none

module serial_command_line_parser import scl_pkg::*; #(
  parameter int unsigned MAX_LINE = MaxLineDef,
  parameter int unsigned MAX_ARGS = MaxArgsDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input request channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  // result request channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            line_valid_o,
  output logic [1:0]      command_code_o,
  output logic            checksum_present_o,
  output logic [3:0]      argument_count_o,
  output logic            line_dropped_o,
  output logic            tx_permitted_o,
  output logic            tx_changed_o,
  output logic            antenna_alive_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_accept;

  // byte in the input register is processed when it makes no result or the
  // result register can take one this cycle
  logic is_term;
  logic has_result;
  logic out_free;
  logic proc;

  line_view_t view;

  assign is_term = (in_byte_q == CharCr) || (in_byte_q == CharLf);
  assign has_result = is_term && !view.len_zero;
  assign out_free = !out_valid_o || !out_stall_i;
  assign proc = in_valid_q && (!has_result || out_free);
  assign in_stall_o = in_valid_q && !proc;
  assign in_accept = in_valid_i && !in_stall_o;

  scl_line_state #(
    .MAX_LINE (MAX_LINE),
    .MAX_ARGS (MAX_ARGS)
  ) u_line (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .data_en_i (proc && !is_term),
    .clear_i   (proc && is_term),
    .byte_i    (in_byte_q),
    .view_o    (view)
  );

  // line end evaluation
  logic [7:0] b1, b2, b3;
  logic       eligible;
  logic       semi_end;
  logic       cks_end;
  logic [7:0] cks_sum;
  body_t      body_end;
  body_t      body_sel;
  logic       rep_valid;
  logic       rep_cks;
  cmd_code_e  rep_code;
  logic       perm;
  logic       tx_q, tx_d;
  logic       alive_q, alive_d;
  logic       changed;

  assign b1 = view.tail[7:0];
  assign b2 = view.tail[15:8];
  assign b3 = view.tail[23:16];
  assign eligible = !view.len_over && view.len_ge_min && view.prefix_ok;
  assign semi_end = (b1 == CharSemi);
  assign cks_end = !semi_end && (b3 == CharSemi);
  // xor of every byte before the semicolon
  assign cks_sum = view.run_xor ^ b1 ^ b2 ^ b3;

  // plain terminator form: the two late body bytes still need reading
  assign body_end = body_step(body_step(view.body, b3, 4'(MAX_ARGS)), b2, 4'(MAX_ARGS));
  assign body_sel = semi_end ? body_end : view.body;

  always_comb begin
    rep_valid = 1'b0;
    rep_cks = 1'b0;
    if (eligible) begin
      if (semi_end) begin
        rep_valid = 1'b1;
      end else if (cks_end) begin
        rep_cks = 1'b1;
        rep_valid = (cks_sum == read_checksum(b2, b1));
      end
    end
  end

  always_comb begin
    rep_code = CMD_UNKNOWN;
    if (rep_valid && body_sel.cmd_len == 2'd3) begin
      unique case (body_sel.cmd_chars)
        CmdTextSts: rep_code = CMD_STS;
        CmdTextIdd: rep_code = CMD_IDD;
        CmdTextGga: rep_code = CMD_GGA;
        default:    rep_code = CMD_UNKNOWN;
      endcase
    end
  end

  // permission granted only by a positive argument of exactly the permit value
  assign perm = (body_sel.field_num >= PermitArg) && (body_sel.arg_val == PermitValue) &&
                !body_sel.arg_neg;

  always_comb begin
    tx_d = tx_q;
    alive_d = alive_q;
    changed = 1'b0;
    if (proc && has_result && rep_code == CMD_STS) begin
      tx_d = perm;
      alive_d = 1'b1;
      changed = (perm != tx_q);
    end
  end

  // control registers
  logic out_valid_q, out_valid_d;
  logic in_valid_d;
  logic load_out;

  assign load_out = proc && has_result;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) in_valid_d = 1'b1;
    else if (proc) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (load_out) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      tx_q <= 1'b0;
      alive_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      out_valid_q <= out_valid_d;
      tx_q <= tx_d;
      alive_q <= alive_d;
    end
  end

  // payload registers, no reset needed
  logic       line_valid_q;
  cmd_code_e  code_q;
  logic       cks_q;
  logic [3:0] args_q;
  logic       dropped_q;
  logic       tx_out_q;
  logic       changed_q;
  logic       alive_out_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) in_byte_q <= rx_byte_i;
    if (load_out) begin
      line_valid_q <= rep_valid;
      code_q <= rep_code;
      cks_q <= rep_cks;
      args_q <= rep_valid ? body_sel.field_num : 4'd0;
      dropped_q <= view.len_over;
      tx_out_q <= tx_d;
      changed_q <= changed;
      alive_out_q <= alive_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign line_valid_o = line_valid_q;
  assign command_code_o = code_q;
  assign checksum_present_o = cks_q;
  assign argument_count_o = args_q;
  assign line_dropped_o = dropped_q;
  assign tx_permitted_o = tx_out_q;
  assign tx_changed_o = changed_q;
  assign antenna_alive_o = alive_out_q;

  // checks on the report logic
  a_invalid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !line_valid_o |-> command_code_o == CMD_UNKNOWN && argument_count_o == 4'd0)
    else $error("invalid line reported a command or arguments");

  a_change_only_sts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_changed_o |-> line_valid_o && command_code_o == CMD_STS)
    else $error("permission change reported on a line that is not a valid status line");

  a_dropped_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_dropped_o |-> !line_valid_o && !checksum_present_o)
    else $error("dropped line reported as valid or with checksum");

  a_permit_needs_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_permitted_o |-> antenna_alive_o)
    else $error("transmit permission without antenna alive");

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the result register could take a result");

endmodule

`default_nettype wire
